// File: design/bts_pkg.sv
package bts_pkg;

    localparam int TEX_ADDR_W = 16;
    localparam int TEXEL_W    = 32;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 9;
    localparam int POS_W      = 8;
    localparam int FRAC_W     = 17;
    localparam int PROD_W     = COORD_W + SIZE_W;
    localparam int CHAN_W     = 8;
    localparam int NUM_TAPS   = 4;
    localparam int HORZ_W     = 27;
    localparam int RES_W      = 48;
    localparam int TEX_DEPTH  = 1 << TEX_ADDR_W;

    localparam logic [SIZE_W-1:0] MAX_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 9'd256;
    localparam logic [SIZE_W-1:0] MIN_SIZE   = 9'd2;

    // apb register index (paddr bit 2)
    localparam logic CFG_WIDTH_IDX  = 1'b0;
    localparam logic CFG_HEIGHT_IDX = 1'b1;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // four neighbor texels: 0 = (x,y), 1 = (x+1,y), 2 = (x,y+1), 3 = (x+1,y+1)
    typedef logic [NUM_TAPS-1:0][TEXEL_W-1:0] texel_quad_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOC,
        S_BASE,
        S_FETCH,
        S_WAIT,
        S_FILT
    } top_state_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_HORZ,
        L_VERT
    } lerp_state_t;

    typedef struct packed {
        logic finishing;
        logic done;
    } lerp_stat_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (s < MIN_SIZE) begin
            r = MIN_SIZE;
        end
        else if (s > hi) begin
            r = hi;
        end
        else begin
            r = s;
        end
        return r;
    endfunction

endpackage

// File: design/bts_lerp.sv
module bts_lerp
    import bts_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  texel_quad_t              quad,
    input  logic [FRAC_W-1:0]        fx,
    input  logic [FRAC_W-1:0]        fy,
    output lerp_stat_t               stat,
    output logic [TEXEL_W-1:0]       color
);

    lerp_state_t state_reg, state_next;
    logic [1:0]  ch_reg, ch_next;
    logic        done_reg, done_next;

    logic signed [HORZ_W-1:0] top_reg, bot_reg;
    logic [TEXEL_W-1:0]       color_reg;

    logic [4:0]              bsel;
    logic [CHAN_W-1:0]       p00, p01, p10, p11;
    logic signed [CHAN_W:0]  d_top, d_bot;
    logic signed [HORZ_W-1:0] top_c, bot_c;
    logic signed [HORZ_W:0]  vdiff;
    logic signed [RES_W-1:0] res;
    logic [CHAN_W-1:0]       chan_val;

    assign bsel = {ch_reg, 3'b000};
    assign p00  = quad[0][bsel +: CHAN_W];
    assign p01  = quad[1][bsel +: CHAN_W];
    assign p10  = quad[2][bsel +: CHAN_W];
    assign p11  = quad[3][bsel +: CHAN_W];

    // horizontal pass, q.16
    always_comb
    begin
        d_top = $signed({1'b0, p01}) - $signed({1'b0, p00});
        d_bot = $signed({1'b0, p11}) - $signed({1'b0, p10});
        top_c = $signed({3'b000, p00, 16'h0000}) + d_top * $signed({1'b0, fx});
        bot_c = $signed({3'b000, p10, 16'h0000}) + d_bot * $signed({1'b0, fx});
    end

    // vertical pass, q.32, then floor and saturate
    always_comb
    begin
        vdiff = $signed({bot_reg[HORZ_W-1], bot_reg}) - $signed({top_reg[HORZ_W-1], top_reg});
        res   = $signed({top_reg, 16'h0000}) + vdiff * $signed({1'b0, fy});
        if (res[RES_W-1]) begin
            chan_val = '0;
        end
        else if (|res[RES_W-2:40]) begin
            chan_val = 8'hFF;
        end
        else begin
            chan_val = res[39:32];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:  if (go) state_next = L_HORZ;
            L_HORZ:  state_next = L_VERT;
            L_VERT:  state_next = (ch_reg == 2'd3) ? L_IDLE : L_HORZ;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        ch_next   = ch_reg;
        done_next = 1'b0;
        case (state_reg)
            L_IDLE:  ch_next = '0;
            L_HORZ:  ch_next = ch_reg;
            L_VERT:
            begin
                ch_next   = ch_reg + 2'd1;
                done_next = (ch_reg == 2'd3);
            end
            default: ch_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= L_IDLE;
            ch_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_HORZ) begin
            top_reg <= top_c;
            bot_reg <= bot_c;
        end
        if (state_reg == L_VERT) begin
            color_reg[bsel +: CHAN_W] <= chan_val;
        end
    end

    assign stat.finishing = (state_reg == L_VERT) && (ch_reg == 2'd3);
    assign stat.done      = done_reg;
    assign color          = color_reg;

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == L_VERT && $past(ch_reg) == 2'd3)
        else $error("lerp done without finishing last channel");

    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == L_IDLE)
        else $error("lerp started while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("lerp done held more than one cycle");

endmodule

// File: design/bilinear_texel_sampler_top.sv
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+-------------------------------------------
// cmd item  | in        | start & !busy            | command, texel_addr, texel_value, u/v_coord
// result    | out       | done (one-cycle strobe)  | filtered_color
// config    | in        | apb psel/penable/pwrite  | paddr, pwdata -> tex_width, tex_height
//
// a write item sets no busy period: the texel lands in memory on the accept edge and busy stays low
// a sample item keeps busy high until the last channel is filtered; the result strobe comes in the first idle cycle,
// where the next item may already be accepted
// the busy period is set by the single-port texture memory (four reads, one a cycle) and the
// channel-serial lerp unit (a horizontal and a vertical pass per channel)
// rst_n clears control and size registers only; texture memory is undefined until written
// results are never held off by the receiver
module bilinear_texel_sampler_top
    import bts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // command items
    input  logic                    start,
    output logic                    busy,
    input  logic                    command,
    input  logic [TEX_ADDR_W-1:0]   texel_addr,
    input  logic [TEXEL_W-1:0]      texel_value,
    input  logic [COORD_W-1:0]      u_coord,
    input  logic [COORD_W-1:0]      v_coord,
    // results
    output logic                    done,
    output logic [TEXEL_W-1:0]      filtered_color
);

    // size registers
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic              cfg_wr;

    top_state_t state_reg, state_next;

    // sample pipeline registers
    logic [COORD_W-1:0]    u_reg, v_reg;
    logic [PROD_W-1:0]     pu_reg, pv_reg;
    logic [POS_W-1:0]      x_reg, y_reg;
    logic [FRAC_W-1:0]     fx_reg, fy_reg;
    logic [TEX_ADDR_W-1:0] base_reg;
    logic [1:0]            tap_reg;
    logic                  rd_pend_reg;
    logic                  go_reg, go_next;
    texel_quad_t           quad_reg;

    // texture memory, one port
    logic [TEXEL_W-1:0]    tex_mem [0:TEX_DEPTH-1];
    logic [TEXEL_W-1:0]    mem_q;
    logic                  mem_we, mem_re;
    logic [TEX_ADDR_W-1:0] mem_addr;
    logic [TEX_ADDR_W-1:0] fetch_addr, fetch_off;

    // locate stage
    logic [SIZE_W-1:0]     xi, yi, x_sel, y_sel;
    logic [PROD_W-1:0]     fx_full, fy_full;
    logic [SIZE_W+POS_W-1:0] row_base;

    logic accept;

    lerp_stat_t lerp_stat;

    assign accept = start && !busy;

    // apb: always ready, write on access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= MAX_WIDTH;
            height_reg <= MAX_HEIGHT;
        end
        else if (cfg_wr) begin
            if (paddr[2] == CFG_WIDTH_IDX) begin
                width_reg <= pwdata[SIZE_W-1:0];
            end
            else begin
                height_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == CFG_HEIGHT_IDX) ? {23'd0, height_reg} : {23'd0, width_reg};

    // effective sizes, clamped to [2, max]
    assign w_eff = clamp_size(width_reg, MAX_WIDTH);
    assign h_eff = clamp_size(height_reg, MAX_HEIGHT);

    // integer position, clamped so that pos+1 stays inside; fraction may reach just under 2
    always_comb
    begin
        xi      = pu_reg[PROD_W-1:16];
        yi      = pv_reg[PROD_W-1:16];
        x_sel   = (xi >= w_eff - 9'd1) ? w_eff - 9'd2 : xi;
        y_sel   = (yi >= h_eff - 9'd1) ? h_eff - 9'd2 : yi;
        fx_full = pu_reg - {x_sel, 16'h0000};
        fy_full = pv_reg - {y_sel, 16'h0000};
    end

    // row start of the top-left texel, wraps modulo memory depth
    assign row_base = {9'd0, y_reg} * {8'd0, w_eff};

    // tap 0: base, 1: base+1, 2: base+w, 3: base+w+1
    assign fetch_off  = (tap_reg[1] ? {7'd0, w_eff} : 16'd0) + {15'd0, tap_reg[0]};
    assign fetch_addr = base_reg + fetch_off;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && command == CMD_SAMPLE) state_next = S_MUL;
            S_MUL:   state_next = S_LOC;
            S_LOC:   state_next = S_BASE;
            S_BASE:  state_next = S_FETCH;
            S_FETCH: if (tap_reg == 2'd3) state_next = S_WAIT;
            S_WAIT:  state_next = S_FILT;
            S_FILT:  if (lerp_stat.finishing) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy     = 1'b1;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = fetch_addr;
        go_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                mem_we   = accept && command == CMD_WRITE;
                mem_addr = texel_addr;
            end
            S_FETCH: mem_re = 1'b1;
            S_WAIT:  go_next = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            tap_reg     <= '0;
            rd_pend_reg <= 1'b0;
            go_reg      <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_re;
            go_reg      <= go_next;
            if (state_reg == S_FETCH) begin
                tap_reg <= tap_reg + 2'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept) begin
            u_reg <= u_coord;
            v_reg <= v_coord;
        end
        if (state_reg == S_MUL) begin
            pu_reg <= {9'd0, u_reg} * {16'd0, w_eff};
            pv_reg <= {9'd0, v_reg} * {16'd0, h_eff};
        end
        if (state_reg == S_LOC) begin
            x_reg  <= x_sel[POS_W-1:0];
            y_reg  <= y_sel[POS_W-1:0];
            fx_reg <= fx_full[FRAC_W-1:0];
            fy_reg <= fy_full[FRAC_W-1:0];
        end
        if (state_reg == S_BASE) begin
            base_reg <= row_base[TEX_ADDR_W-1:0] + {8'd0, x_reg};
        end
        // taps arrive in order; after four shifts tap 0 sits at index 0
        if (rd_pend_reg) begin
            quad_reg <= {mem_q, quad_reg[NUM_TAPS-1:1]};
        end
    end

    // texture memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            tex_mem[mem_addr] <= texel_value;
        end
        else if (mem_re) begin
            mem_q <= tex_mem[mem_addr];
        end
    end

    bts_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .quad  (quad_reg),
        .fx    (fx_reg),
        .fy    (fy_reg),
        .stat  (lerp_stat),
        .color (filtered_color)
    );

    assign done = lerp_stat.done;

    a_done_from_filter: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE && $past(state_reg) == S_FILT)
        else $error("result strobe outside filter completion");

    a_sample_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_SAMPLE |=> busy)
        else $error("sample item did not start");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_WRITE |=> !busy)
        else $error("write item stalled the block");

endmodule
